FILE: rtl/hcd_pkg.sv
// Shared types and constants for the chunked body decoder.
package hcd_pkg;

    localparam int SIZE_BITS = 32;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [1:0] SKIP_COUNT = 2'd2;

    typedef enum logic [2:0] {
        PH_SIZE = 3'd0,
        PH_DATA = 3'd1,
        PH_SKIP = 3'd2,
        PH_DONE = 3'd3,
        PH_ERR  = 3'd4
    } phase_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       stream_done;
        logic       stream_error;
    } result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.is_hex = 1'b0;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage

FILE: rtl/hcd_parser.sv
// Per-byte chunk parser: state registers and the result for the current word.
module hcd_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       in_byte,
    output hcd_pkg::result_t result
);

    localparam int SB = hcd_pkg::SIZE_BITS;

    hcd_pkg::phase_t phase_reg, phase_next;
    logic [SB-1:0]   size_accum_reg, size_accum_next;
    logic            digit_seen_reg, digit_seen_next;
    logic            line_bad_reg, line_bad_next;
    logic            pending_cr_reg, pending_cr_next;
    logic [SB-1:0]   bytes_left_reg, bytes_left_next;
    logic [1:0]      skip_left_reg, skip_left_next;

    hcd_pkg::hex_t   hex;
    logic            bad;
    logic [SB-1:0]   left_dec;
    logic [1:0]      skip_dec;

    assign hex      = hcd_pkg::hex_decode(in_byte);
    assign left_dec = bytes_left_reg - SB'(1);
    assign skip_dec = skip_left_reg - 2'd1;

    always_comb begin
        phase_next      = phase_reg;
        size_accum_next = size_accum_reg;
        digit_seen_next = digit_seen_reg;
        line_bad_next   = line_bad_reg;
        pending_cr_next = pending_cr_reg;
        bytes_left_next = bytes_left_reg;
        skip_left_next  = skip_left_reg;
        bad             = line_bad_reg;
        unique case (phase_reg)
            hcd_pkg::PH_SIZE: begin
                if (pending_cr_reg && in_byte == hcd_pkg::CHAR_LF) begin
                    if (line_bad_reg || !digit_seen_reg) begin
                        phase_next = hcd_pkg::PH_ERR;
                    end else if (size_accum_reg == '0) begin
                        phase_next = hcd_pkg::PH_DONE;
                    end else begin
                        bytes_left_next = size_accum_reg;
                        phase_next      = hcd_pkg::PH_DATA;
                    end
                    size_accum_next = '0;
                    digit_seen_next = 1'b0;
                    line_bad_next   = 1'b0;
                    pending_cr_next = 1'b0;
                end else begin
                    if (pending_cr_reg) begin
                        bad = 1'b1;
                    end
                    pending_cr_next = 1'b0;
                    if (in_byte == hcd_pkg::CHAR_CR) begin
                        pending_cr_next = 1'b1;
                    end else if (!hex.is_hex) begin
                        bad = 1'b1;
                    end else begin
                        digit_seen_next = 1'b1;
                        if (!bad) begin
                            if (size_accum_reg[SB-1:SB-4] != 4'd0) begin
                                bad = 1'b1;
                            end else begin
                                size_accum_next = {size_accum_reg[SB-5:0], hex.value};
                            end
                        end
                    end
                    line_bad_next = bad;
                end
            end
            hcd_pkg::PH_DATA: begin
                bytes_left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next     = hcd_pkg::PH_SKIP;
                    skip_left_next = hcd_pkg::SKIP_COUNT;
                end
            end
            hcd_pkg::PH_SKIP: begin
                skip_left_next = skip_dec;
                if (skip_dec == 2'd0) begin
                    phase_next      = hcd_pkg::PH_SIZE;
                    size_accum_next = '0;
                    digit_seen_next = 1'b0;
                    line_bad_next   = 1'b0;
                    pending_cr_next = 1'b0;
                end
            end
            hcd_pkg::PH_DONE, hcd_pkg::PH_ERR: begin
            end
            default: begin
                phase_next = hcd_pkg::PH_ERR;
            end
        endcase
    end

    always_comb begin
        result.payload_valid = (phase_reg == hcd_pkg::PH_DATA);
        result.payload_byte  = (phase_reg == hcd_pkg::PH_DATA) ? in_byte : 8'd0;
        result.stream_done   = (phase_next == hcd_pkg::PH_DONE);
        result.stream_error  = (phase_next == hcd_pkg::PH_ERR);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= hcd_pkg::PH_SIZE;
            size_accum_reg <= '0;
            digit_seen_reg <= 1'b0;
            line_bad_reg   <= 1'b0;
            pending_cr_reg <= 1'b0;
            bytes_left_reg <= '0;
            skip_left_reg  <= 2'd0;
        end else if (step) begin
            phase_reg      <= phase_next;
            size_accum_reg <= size_accum_next;
            digit_seen_reg <= digit_seen_next;
            line_bad_reg   <= line_bad_next;
            pending_cr_reg <= pending_cr_next;
            bytes_left_reg <= bytes_left_next;
            skip_left_reg  <= skip_left_next;
        end
    end

endmodule

FILE: rtl/http_chunked_decoder.sv
// Chunked body decoder top level: parser plus registered result word.
//
//   channel | dir | ports                                    | handshake
//   s_      | in  | s_in_byte                                | s_valid / s_ready
//   m_      | out | m_payload_valid m_payload_byte           | m_valid / m_ready
//           |     | m_stream_done m_stream_error             |
//
// One word per cycle while m_ready does not stall; its result appears in the output
// register in the cycle after acceptance. The parser state update and the result
// register close in the same cycle, so the per-byte state machine sets the rate.
// Reset (aresetn low, synchronous) returns to the size line and empties the
// result register. s_ready stays high while the result register is empty or
// being drained; a stalled m_ready holds the result and stops intake.
module http_chunked_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_payload_valid,
    output logic [7:0] m_payload_byte,
    output logic       m_stream_done,
    output logic       m_stream_error
);

    logic             accept;
    hcd_pkg::result_t result;
    hcd_pkg::result_t out_reg;
    logic             m_valid_reg, m_valid_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    hcd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .in_byte (s_in_byte),
        .result  (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_payload_valid = out_reg.payload_valid;
    assign m_payload_byte  = out_reg.payload_byte;
    assign m_stream_done   = out_reg.stream_done;
    assign m_stream_error  = out_reg.stream_error;

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_stream_done && m_stream_error))
        else $error("done and error both set");

    a_no_payload_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload_valid) |-> (!m_stream_done && !m_stream_error))
        else $error("payload word with end flag set");

    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stream_done) |=> m_stream_done)
        else $error("done flag dropped");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stream_error) |=> m_stream_error)
        else $error("error flag dropped");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted word produced no result");

endmodule
